@@ src/register_file_alu_ops_assert.svh @@
// Assertion macros for the register file ALU.
`ifndef REGISTER_FILE_ALU_OPS_ASSERT_SVH
`define REGISTER_FILE_ALU_OPS_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define RFAO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("register_file_alu_ops: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RFAO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("register_file_alu_ops: assertion failed");

`else

`define RFAO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RFAO_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ src/rfao_pkg.sv @@
// Shared types, constants and helpers for the register file ALU.
package rfao_pkg;

    localparam int REG_COUNT = 8;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;
    localparam int IMM_W     = 25;
    localparam int OP_W      = 3;
    localparam int RF_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CMP_W     = IDX_W + RF_AW;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 3'd0,
        OP_MUL  = 3'd1,
        OP_DIV  = 3'd2,
        OP_LOAD = 3'd3,
        OP_CMOV = 3'd4,
        OP_NAND = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDOP,
        ST_EXEC,
        ST_DIV,
        ST_WB,
        ST_RDA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_ops;
        logic exec;
        logic div_step;
        logic wb;
        logic rd_a;
    } t_dp_cmd;

    typedef struct packed {
        logic is_div;
        logic c_zero;
        logic div_last;
    } t_dp_sts;

    function automatic logic rf_in_range(input logic [IDX_W-1:0] idx);
        return {{RF_AW{1'b0}}, idx} < CMP_W'(REG_COUNT);
    endfunction

    function automatic logic [RF_AW-1:0] rf_addr(input logic [IDX_W-1:0] idx);
        logic [CMP_W-1:0] wide;
        wide = {{RF_AW{1'b0}}, idx};
        return wide[RF_AW-1:0];
    endfunction

endpackage

@@ src/register_file_alu_ops.sv @@
// Top level of the register file ALU: controller plus datapath.
// One request is taken when start is high and busy is low; busy then stays high until
// the result has been shown. The result sits on o_result_value, o_wrote and
// o_div_by_zero for the single cycle in which o_done is high and must be taken then,
// since the block cannot be stalled. A divide with a nonzero divisor runs through the
// restoring divider, which produces one quotient bit per cycle, before the write-back.
// The register file is read through two registered ports (sources first, destination
// after the write-back) and clears to zero at reset through per-entry valid bits.
`include "register_file_alu_ops_assert.svh"

module register_file_alu_ops (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rfao_pkg::OP_W-1:0]    i_cmd,
    input  logic [rfao_pkg::IDX_W-1:0]   i_dest_reg,
    input  logic [rfao_pkg::IDX_W-1:0]   i_src_b_reg,
    input  logic [rfao_pkg::IDX_W-1:0]   i_src_c_reg,
    input  logic [rfao_pkg::IMM_W-1:0]   i_immediate,
    output logic                         o_done,
    output logic [rfao_pkg::DATA_W-1:0]  o_result_value,
    output logic                         o_wrote,
    output logic                         o_div_by_zero
);
    import rfao_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rfao_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (dp_sts),
        .busy     (busy),
        .o_done   (o_done),
        .o_dp_cmd (dp_cmd)
    );

    rfao_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .i_cmd          (i_cmd),
        .i_dest_reg     (i_dest_reg),
        .i_src_b_reg    (i_src_b_reg),
        .i_src_c_reg    (i_src_c_reg),
        .i_immediate    (i_immediate),
        .o_sts          (dp_sts),
        .o_result_value (o_result_value),
        .o_wrote        (o_wrote),
        .o_div_by_zero  (o_div_by_zero)
    );

    `RFAO_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `RFAO_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done && !busy)
    `RFAO_ASSERT_IMP(a_dz_no_write, i_clk, i_rst_n, o_done && o_div_by_zero, !o_wrote)
    `RFAO_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy)

endmodule

@@ src/rfao_ctrl.sv @@
// Controller state machine for the register file ALU.
module rfao_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  rfao_pkg::t_dp_sts i_sts,
    output logic              busy,
    output logic              o_done,
    output rfao_pkg::t_dp_cmd o_dp_cmd
);
    import rfao_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        busy     = 1'b1;
        o_done   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = ST_RDOP;
                end
            end
            ST_RDOP: begin
                o_dp_cmd.rd_ops = 1'b1;
                n_state         = ST_EXEC;
            end
            ST_EXEC: begin
                o_dp_cmd.exec = 1'b1;
                // divide by zero skips the divider
                if (i_sts.is_div && !i_sts.c_zero) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_WB;
                end
            end
            ST_DIV: begin
                o_dp_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                o_dp_cmd.wb = 1'b1;
                n_state     = ST_RDA;
            end
            ST_RDA: begin
                o_dp_cmd.rd_a = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/rfao_dp.sv @@
// Datapath: register file, ALU, multiplier and bit-serial divider.
module rfao_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rfao_pkg::t_dp_cmd            i_dp_cmd,
    input  logic [rfao_pkg::OP_W-1:0]    i_cmd,
    input  logic [rfao_pkg::IDX_W-1:0]   i_dest_reg,
    input  logic [rfao_pkg::IDX_W-1:0]   i_src_b_reg,
    input  logic [rfao_pkg::IDX_W-1:0]   i_src_c_reg,
    input  logic [rfao_pkg::IMM_W-1:0]   i_immediate,
    output rfao_pkg::t_dp_sts            o_sts,
    output logic [rfao_pkg::DATA_W-1:0]  o_result_value,
    output logic                         o_wrote,
    output logic                         o_div_by_zero
);
    import rfao_pkg::*;

    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_a;
    logic [IDX_W-1:0]  r_b;
    logic [IDX_W-1:0]  r_c;
    logic [IMM_W-1:0]  r_imm;

    logic [DATA_W-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [DATA_W-1:0] r_rd0;
    logic [DATA_W-1:0] r_rd1;
    logic              r_rd0_ok;
    logic              r_rd1_ok;

    logic [DATA_W-1:0] r_res;
    logic              r_we;
    logic              r_dz;
    logic              r_wrote;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;

    logic [DATA_W-1:0] op_b;
    logic [DATA_W-1:0] op_c;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] alu_res;
    logic              alu_we;
    logic              c_zero;
    logic [IDX_W-1:0]  rd0_idx;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] n_quo;
    logic [DATA_W-1:0] wb_val;
    logic              wr_en;

    assign op_b    = r_rd0_ok ? r_rd0 : '0;
    assign op_c    = r_rd1_ok ? r_rd1 : '0;
    assign c_zero  = (op_c == '0);
    assign prod    = op_b * op_c;
    assign rd0_idx = i_dp_cmd.rd_a ? r_a : r_b;

    always_comb begin
        alu_res = '0;
        alu_we  = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                alu_res = op_b + op_c;
                alu_we  = 1'b1;
            end
            OP_MUL: begin
                alu_res = prod;
                alu_we  = 1'b1;
            end
            OP_DIV: begin
                alu_we = !c_zero;
            end
            OP_LOAD: begin
                alu_res = DATA_W'(r_imm);
                alu_we  = 1'b1;
            end
            OP_CMOV: begin
                alu_res = op_b;
                alu_we  = !c_zero;
            end
            OP_NAND: begin
                alu_res = ~(op_b & op_c);
                alu_we  = 1'b1;
            end
            default: begin
                alu_res = '0;
                alu_we  = 1'b0;
            end
        endcase
    end

    // restoring divide: one quotient bit per step
    always_comb begin
        rem_sh = {r_rem, r_quo[DATA_W-1]};
        diff   = rem_sh - {1'b0, op_c};
        if (!diff[DATA_W]) begin
            n_rem = diff[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b0};
        end
    end

    assign wb_val = (r_op == OP_DIV) ? r_quo : r_res;
    assign wr_en  = i_dp_cmd.wb && r_we && rf_in_range(r_a);

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_op  <= i_cmd;
            r_a   <= i_dest_reg;
            r_b   <= i_src_b_reg;
            r_c   <= i_src_c_reg;
            r_imm <= i_immediate;
        end
    end

    // register file storage and registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[rf_addr(r_a)] <= wb_val;
        end
        if (i_dp_cmd.rd_ops || i_dp_cmd.rd_a) begin
            r_rd0 <= r_mem[rf_addr(rd0_idx)];
        end
        if (i_dp_cmd.rd_ops) begin
            r_rd1 <= r_mem[rf_addr(r_c)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd0_ok <= 1'b0;
            r_rd1_ok <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[rf_addr(r_a)] <= 1'b1;
            end
            // entries never written read as zero
            if (i_dp_cmd.rd_ops || i_dp_cmd.rd_a) begin
                r_rd0_ok <= r_vld[rf_addr(rd0_idx)] && rf_in_range(rd0_idx);
            end
            if (i_dp_cmd.rd_ops) begin
                r_rd1_ok <= r_vld[rf_addr(r_c)] && rf_in_range(r_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            r_res <= alu_res;
            r_we  <= alu_we;
            r_dz  <= (r_op == OP_DIV) && c_zero;
            r_rem <= '0;
            r_quo <= op_b;
            r_cnt <= '0;
        end
        if (i_dp_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_dp_cmd.wb) begin
            r_wrote <= wr_en;
        end
    end

    assign o_sts.is_div   = (r_op == OP_DIV);
    assign o_sts.c_zero   = c_zero;
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    assign o_result_value = op_b;
    assign o_wrote        = r_wrote;
    assign o_div_by_zero  = r_dz;

endmodule

@@ dv/register_file_alu_ops_test.sv @@
// Self-checking testbench for the register file ALU: directed table, then random requests.
`timescale 1ns / 100ps

module register_file_alu_ops_test;
    import rfao_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
    localparam int GAP_MAX      = 10;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 60;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int DIRECTED_N   = 22;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              wrote;
        logic              dz;
    } t_alu_result;

    typedef struct {
        logic [OP_W-1:0]  cmd;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IMM_W-1:0] imm;
        bit               known;
        t_alu_result      want;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_cmd;
    logic [IDX_W-1:0]   i_dest_reg;
    logic [IDX_W-1:0]   i_src_b_reg;
    logic [IDX_W-1:0]   i_src_c_reg;
    logic [IMM_W-1:0]   i_immediate;
    logic               o_done;
    logic [DATA_W-1:0]  o_result_value;
    logic               o_wrote;
    logic               o_div_by_zero;

    logic [DATA_W-1:0]  shadow_rf [REG_COUNT];
    t_alu_result        pending_results [$];
    bit                 burst_mode;
    int                 err_count;
    int                 n_checked;
    int                 n_div_zero;
    int                 n_no_write;

    // Expected values are typed in only where they follow directly from the state.
    t_directed_row directed_tbl [DIRECTED_N] = '{
        '{OP_ADD,   3'd0, 3'd1, 3'd2, 25'h0,       1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{OP_DIV,   3'd3, 3'd1, 3'd2, 25'h0,       1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
        '{OP_CMOV,  3'd4, 3'd1, 3'd2, 25'h0,       1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
        '{OP_LOAD,  3'd7, 3'd0, 3'd0, 25'h1FFFFFF, 1'b1, '{32'h01FF_FFFF, 1'b1, 1'b0}},
        '{OP_LOAD,  3'd6, 3'd0, 3'd0, 25'h0,       1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{OP_NAND,  3'd5, 3'd0, 3'd0, 25'h0,       1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{OP_ADD,   3'd1, 3'd5, 3'd5, 25'h0,       1'b0, '0},
        '{OP_MUL,   3'd2, 3'd5, 3'd5, 25'h0,       1'b1, '{32'h0000_0001, 1'b1, 1'b0}},
        '{OP_DIV,   3'd3, 3'd5, 3'd2, 25'h0,       1'b0, '0},
        '{OP_DIV,   3'd3, 3'd7, 3'd5, 25'h0,       1'b0, '0},
        '{OP_CMOV,  3'd4, 3'd7, 3'd2, 25'h0,       1'b0, '0},
        '{OP_RSVD6, 3'd7, 3'd0, 3'd1, 25'h1234567, 1'b0, '0},
        '{OP_RSVD7, 3'd5, 3'd6, 3'd7, 25'h1FFFFFF, 1'b0, '0},
        '{OP_ADD,   3'd0, 3'd5, 3'd2, 25'h0,       1'b0, '0},
        '{OP_MUL,   3'd0, 3'd7, 3'd7, 25'h0,       1'b0, '0},
        '{OP_NAND,  3'd0, 3'd5, 3'd5, 25'h0,       1'b0, '0},
        '{OP_LOAD,  3'd0, 3'd3, 3'd4, 25'h1555555, 1'b0, '0},
        '{OP_LOAD,  3'd1, 3'd2, 3'd6, 25'h0AAAAAA, 1'b0, '0},
        '{OP_DIV,   3'd2, 3'd0, 3'd1, 25'h0,       1'b0, '0},
        '{OP_DIV,   3'd7, 3'd5, 3'd6, 25'h0,       1'b1, '{32'h01FF_FFFF, 1'b0, 1'b1}},
        '{OP_CMOV,  3'd3, 3'd3, 3'd3, 25'h0,       1'b0, '0},
        '{OP_DIV,   3'd4, 3'd4, 3'd4, 25'h0,       1'b0, '0}
    };

    register_file_alu_ops u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_dest_reg     (i_dest_reg),
        .i_src_b_reg    (i_src_b_reg),
        .i_src_c_reg    (i_src_c_reg),
        .i_immediate    (i_immediate),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_wrote        (o_wrote),
        .o_div_by_zero  (o_div_by_zero)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [DATA_W-1:0] shadow_read(input logic [IDX_W-1:0] idx);
        if (int'(idx) < REG_COUNT) return shadow_rf[idx];
        return '0;
    endfunction

    // Execute one instruction on the shadow register file and return what the block reports.
    function automatic t_alu_result execute_instr(input logic [OP_W-1:0] cmd,
                                                  input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b,
                                                  input logic [IDX_W-1:0] c,
                                                  input logic [IMM_W-1:0] imm);
        logic [DATA_W-1:0] opb;
        logic [DATA_W-1:0] opc;
        logic [DATA_W-1:0] v;
        logic              do_wr;
        t_alu_result       r;
        opb   = shadow_read(b);
        opc   = shadow_read(c);
        v     = '0;
        do_wr = 1'b0;
        r     = '0;
        case (cmd)
            OP_ADD: begin
                v     = opb + opc;
                do_wr = 1'b1;
            end
            OP_MUL: begin
                v     = opb * opc;
                do_wr = 1'b1;
            end
            OP_DIV: begin
                if (opc == '0) begin
                    r.dz = 1'b1;
                end else begin
                    v     = opb / opc;
                    do_wr = 1'b1;
                end
            end
            OP_LOAD: begin
                v     = DATA_W'(imm);
                do_wr = 1'b1;
            end
            OP_CMOV: begin
                if (opc != '0) begin
                    v     = opb;
                    do_wr = 1'b1;
                end
            end
            OP_NAND: begin
                v     = ~(opb & opc);
                do_wr = 1'b1;
            end
            default: ;
        endcase
        if (do_wr && int'(a) < REG_COUNT) begin
            shadow_rf[a] = v;
            r.wrote      = 1'b1;
        end
        r.value = shadow_read(a);
        return r;
    endfunction

    // Drive one request and hold it until accepted; start stays high afterwards.
    task automatic issue_instr(input logic [OP_W-1:0] cmd, input logic [IDX_W-1:0] a,
                               input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c,
                               input logic [IMM_W-1:0] imm, input bit known,
                               input t_alu_result typed);
        int          gap;
        t_alu_result predicted;
        gap = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (!start) start <= 1'b1;
        i_cmd       <= cmd;
        i_dest_reg  <= a;
        i_src_b_reg <= b;
        i_src_c_reg <= c;
        i_immediate <= imm;
        do @(posedge i_clk); while (busy);
        predicted = execute_instr(cmd, a, b, c, imm);
        pending_results.push_back(known ? typed : predicted);
    endtask

    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: value %h", o_result_value);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (want.dz) n_div_zero++;
                if (!want.wrote) n_no_write++;
                if (o_result_value !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, o_result_value);
                    err_count++;
                end
                if (o_wrote !== want.wrote) begin
                    $error("wrote: expected %b, got %b", want.wrote, o_wrote);
                    err_count++;
                end
                if (o_div_by_zero !== want.dz) begin
                    $error("div_by_zero: expected %b, got %b", want.dz, o_div_by_zero);
                    err_count++;
                end
            end
        end
    end

    initial begin
        logic [OP_W-1:0]  cmd;
        logic [IMM_W-1:0] imm;
        int               sel;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_dest_reg  = '0;
        i_src_b_reg = '0;
        i_src_c_reg = '0;
        i_immediate = '0;
        burst_mode  = 1'b0;
        err_count   = 0;
        n_checked   = 0;
        n_div_zero  = 0;
        n_no_write  = 0;
        for (int r = 0; r < REG_COUNT; r++) shadow_rf[r] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++) begin
            burst_mode = (i >= DIRECTED_N / 2);
            issue_instr(directed_tbl[i].cmd, directed_tbl[i].a, directed_tbl[i].b,
                        directed_tbl[i].c, directed_tbl[i].imm, directed_tbl[i].known,
                        directed_tbl[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Alternate stretches of back-to-back requests with randomly gapped ones.
            burst_mode = ((n / 50) % 4 == 3);
            sel = $urandom_range(0, 99);
            if (sel < 15)      cmd = OP_ADD;
            else if (sel < 30) cmd = OP_MUL;
            else if (sel < 45) cmd = OP_DIV;
            else if (sel < 62) cmd = OP_LOAD;
            else if (sel < 75) cmd = OP_CMOV;
            else if (sel < 92) cmd = OP_NAND;
            else if (sel < 96) cmd = OP_RSVD6;
            else               cmd = OP_RSVD7;
            case ($urandom_range(0, 7))
                0:       imm = '0;
                1:       imm = '1;
                2:       imm = IMM_W'($urandom_range(1, 15));
                default: imm = IMM_W'($urandom());
            endcase
            issue_instr(cmd, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                        IDX_W'($urandom_range(0, 7)), imm, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results: %0d divides by zero, %0d left the destination as it was",
                 n_checked, n_div_zero, n_no_write);
        if (err_count == 0) begin
            $display("register_file_alu_ops test passed");
        end else begin
            $display("register_file_alu_ops test failed");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("register_file_alu_ops test failed");
        $finish;
    end

endmodule

@@ register_file_alu_ops.f @@
+incdir+src
src/rfao_pkg.sv
src/rfao_ctrl.sv
src/rfao_dp.sv
src/register_file_alu_ops.sv
dv/register_file_alu_ops_test.sv
